// ----- hw/rtl/rfcb_pkg.sv -----
package rfcb_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [1:0] {
    CRC_NONE  = 2'd0,
    CRC_8     = 2'd1,
    CRC_16_Z  = 2'd2,
    CRC_16_F  = 2'd3
  } crc_mode_e;

  typedef enum logic [1:0] {
    FK_PLAIN  = 2'd0,
    FK_LEGACY = 2'd1,
    FK_HEADER = 2'd2
  } frame_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CRC_MODE   = 2'd0,
    REG_FRAME_KIND = 2'd1,
    REG_NETWORK_ID = 2'd2,
    REG_SIZE_BYTE  = 2'd3
  } cfg_reg_e;

  localparam logic [7:0]  Crc8Seed     = 8'h71;
  localparam logic [15:0] Crc16SeedOne = 16'hFFFF;
  localparam logic [15:0] Crc16SeedZer = 16'h0000;
  localparam logic [7:0]  LegacyAddr0  = 8'h31;
  localparam logic [7:0]  LegacyAddr1  = 8'hFA;
  localparam logic [7:0]  LegacyAddr2  = 8'hB6;

  typedef struct packed {
    crc_mode_e   crc_mode;
    logic [1:0]  frame_kind;
    logic [31:0] network_id;
    logic [7:0]  header_size_byte;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] crc;
  } item_t;

  // crc-8, poly 0x07, msb first
  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // ccitt crc-16, poly 0x1021, msb first
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // seeds with the legacy address prefix already folded in
  localparam logic [15:0] LegacySeedZer =
    crc16_byte(crc16_byte(crc16_byte(Crc16SeedZer, LegacyAddr0), LegacyAddr1), LegacyAddr2);
  localparam logic [15:0] LegacySeedOne =
    crc16_byte(crc16_byte(crc16_byte(Crc16SeedOne, LegacyAddr0), LegacyAddr1), LegacyAddr2);

endpackage

// ----- hw/rtl/rfcb_if.sv -----
interface rfcb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface rfcb_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink (input valid, frame_byte, frame_end, output ready);
endinterface

interface rfcb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rfcb_pkg::CfgIdxW-1:0]  index;
  logic [rfcb_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/rfcb_crc.sv -----
module rfcb_crc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                update_i,
  input  logic [7:0]          data_byte_i,
  input  logic                first_byte_i,
  input  rfcb_pkg::cfg_t      cfg_i,
  output logic [15:0]         crc_o
);

  logic [15:0] crc_q, crc_d;
  logic [15:0] seed;
  logic [15:0] base;
  logic        legacy;

  assign legacy = (cfg_i.frame_kind == rfcb_pkg::FK_LEGACY);

  always_comb begin
    unique case (cfg_i.crc_mode)
      rfcb_pkg::CRC_NONE: seed = 16'h0000;
      rfcb_pkg::CRC_8:    seed = {8'h00, rfcb_pkg::Crc8Seed};
      rfcb_pkg::CRC_16_Z: seed = legacy ? rfcb_pkg::LegacySeedZer : rfcb_pkg::Crc16SeedZer;
      rfcb_pkg::CRC_16_F: seed = legacy ? rfcb_pkg::LegacySeedOne : rfcb_pkg::Crc16SeedOne;
      default:            seed = 16'h0000;
    endcase
  end

  assign base = first_byte_i ? seed : crc_q;

  always_comb begin
    unique case (cfg_i.crc_mode)
      rfcb_pkg::CRC_NONE: crc_d = base;
      rfcb_pkg::CRC_8:    crc_d = {8'h00, rfcb_pkg::crc8_byte(base[7:0], data_byte_i)};
      default:            crc_d = rfcb_pkg::crc16_byte(base, data_byte_i);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= 16'h0000;
    end else if (update_i) begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_d;

endmodule

// ----- hw/rtl/rfcb_emit.sv -----
module rfcb_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  rfcb_pkg::item_t item_i,
  input  rfcb_pkg::cfg_t  cfg_i,
  output logic            take_o,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [7:0]      frame_byte_o,
  output logic            frame_end_o
);

  typedef enum logic [8:0] {
    SLOT_NID_HI  = 9'b0_0000_0001,
    SLOT_NID_MID = 9'b0_0000_0010,
    SLOT_NID_LOA = 9'b0_0000_0100,
    SLOT_NID_LOB = 9'b0_0000_1000,
    SLOT_SIZE    = 9'b0_0001_0000,
    SLOT_SEED    = 9'b0_0010_0000,
    SLOT_DATA    = 9'b0_0100_0000,
    SLOT_CRC_HI  = 9'b0_1000_0000,
    SLOT_CRC_LO  = 9'b1_0000_0000
  } slot_e;

  slot_e       slot_q, slot_d, start_slot;
  logic        valid_q;
  logic [7:0]  data_q;
  logic        last_q;
  logic [15:0] crc_q;
  logic        is_final;
  logic        is_end;
  logic        no_crc;
  logic        is_crc8;

  assign no_crc  = (cfg_i.crc_mode == rfcb_pkg::CRC_NONE);
  assign is_crc8 = (cfg_i.crc_mode == rfcb_pkg::CRC_8);

  assign start_slot = (item_i.first_byte && cfg_i.frame_kind == rfcb_pkg::FK_HEADER) ?
                      SLOT_NID_HI : SLOT_DATA;

  always_comb begin
    slot_d       = slot_q;
    frame_byte_o = data_q;
    is_end       = 1'b0;
    is_final     = 1'b0;
    unique case (slot_q)
      SLOT_NID_HI: begin
        frame_byte_o = cfg_i.network_id[31:24];
        slot_d       = SLOT_NID_MID;
      end
      SLOT_NID_MID: begin
        frame_byte_o = cfg_i.network_id[23:16];
        slot_d       = SLOT_NID_LOA;
      end
      SLOT_NID_LOA: begin
        frame_byte_o = cfg_i.network_id[7:0];
        slot_d       = SLOT_NID_LOB;
      end
      SLOT_NID_LOB: begin
        frame_byte_o = cfg_i.network_id[7:0];
        slot_d       = SLOT_SIZE;
      end
      SLOT_SIZE: begin
        frame_byte_o = cfg_i.header_size_byte;
        slot_d       = is_crc8 ? SLOT_SEED : SLOT_DATA;
      end
      SLOT_SEED: begin
        frame_byte_o = rfcb_pkg::Crc8Seed;
        slot_d       = SLOT_DATA;
      end
      SLOT_DATA: begin
        frame_byte_o = data_q;
        is_end       = last_q && no_crc;
        is_final     = !last_q || no_crc;
        slot_d       = is_crc8 ? SLOT_CRC_LO : SLOT_CRC_HI;
      end
      SLOT_CRC_HI: begin
        frame_byte_o = crc_q[15:8];
        slot_d       = SLOT_CRC_LO;
      end
      SLOT_CRC_LO: begin
        frame_byte_o = crc_q[7:0];
        is_end       = 1'b1;
        is_final     = 1'b1;
      end
      default: begin
        slot_d = SLOT_DATA;
      end
    endcase
  end

  assign take_o      = !valid_q || (is_final && ready_i);
  assign valid_o     = valid_q;
  assign frame_end_o = is_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      slot_q  <= SLOT_DATA;
    end else if (load_i) begin
      valid_q <= 1'b1;
      slot_q  <= start_slot;
    end else if (valid_q && ready_i) begin
      if (is_final) begin
        valid_q <= 1'b0;
      end else begin
        slot_q <= slot_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= item_i.data_byte;
      last_q <= item_i.last_byte;
      crc_q  <= item_i.crc;
    end
  end

endmodule

// ----- hw/rtl/radio_frame_crc_builder.sv -----
// path: an accepted byte is held in the input register, then loaded into the emitter
// register, which offers its frame bytes on the output port
// throughput: one input byte per cycle while each byte yields one frame byte and the output
// is unstalled; a byte that opens a header or closes a frame holds the single output byte port
// reset: crc mode crc16 seed ffff, plain framing, network id and size byte zero,
// running crc zero, both pipeline registers empty
module radio_frame_crc_builder (
  input  logic          clk_i,
  input  logic          rst_ni,
  rfcb_byte_if.sink     data_in_i,
  rfcb_frame_if.source  frame_o,
  rfcb_cfg_if.sink      cfg_i
);

  rfcb_pkg::cfg_t  cfg_q;
  rfcb_pkg::item_t item;
  logic            in_xfer;
  logic            a_valid_q;
  logic [7:0]      a_data_q;
  logic            a_first_q;
  logic            a_last_q;
  logic            a_move;
  logic            b_take;
  logic [15:0]     crc_next;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crc_mode         <= rfcb_pkg::CRC_16_F;
      cfg_q.frame_kind       <= rfcb_pkg::FK_PLAIN;
      cfg_q.network_id       <= 32'h0;
      cfg_q.header_size_byte <= 8'h00;
    end else if (cfg_i.valid) begin
      unique case (rfcb_pkg::cfg_reg_e'(cfg_i.index))
        rfcb_pkg::REG_CRC_MODE:   cfg_q.crc_mode   <= rfcb_pkg::crc_mode_e'(cfg_i.data[1:0]);
        rfcb_pkg::REG_FRAME_KIND: cfg_q.frame_kind <= cfg_i.data[1:0];
        rfcb_pkg::REG_NETWORK_ID: cfg_q.network_id <= cfg_i.data[31:0];
        rfcb_pkg::REG_SIZE_BYTE:  cfg_q.header_size_byte <= cfg_i.data[7:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  assign a_move          = a_valid_q && b_take;
  assign data_in_i.ready = !a_valid_q || b_take;
  assign in_xfer         = data_in_i.valid && data_in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_xfer) begin
      a_valid_q <= 1'b1;
    end else if (a_move) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_data_q  <= data_in_i.data_byte;
      a_first_q <= data_in_i.first_byte;
      a_last_q  <= data_in_i.last_byte;
    end
  end

  rfcb_crc u_crc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .update_i     (a_move),
    .data_byte_i  (a_data_q),
    .first_byte_i (a_first_q),
    .cfg_i        (cfg_q),
    .crc_o        (crc_next)
  );

  assign item.data_byte  = a_data_q;
  assign item.first_byte = a_first_q;
  assign item.last_byte  = a_last_q;
  assign item.crc        = crc_next;

  rfcb_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (a_move),
    .item_i       (item),
    .cfg_i        (cfg_q),
    .take_o       (b_take),
    .valid_o      (frame_o.valid),
    .ready_i      (frame_o.ready),
    .frame_byte_o (frame_o.frame_byte),
    .frame_end_o  (frame_o.frame_end)
  );

`ifndef SYNTH
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> a_valid_q)
    else $error("accepted byte missing from input register");

  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !b_take) |=> (a_valid_q && $stable(a_data_q) && $stable(a_last_q)))
    else $error("stalled byte lost or changed");

  a_end_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_o.valid && frame_o.ready && frame_o.frame_end) |-> b_take)
    else $error("frame end transfer did not free the emitter");
`endif

endmodule
